[rtl/core/rhmw_pkg.sv]
// shared types and codes for the right-hand maze walker
package rhmw_pkg;

    // input word kinds
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // step outcome codes
    typedef enum logic [2:0] {
        ACT_LEFT    = 3'd0,
        ACT_FORWARD = 3'd1,
        ACT_RIGHT   = 3'd2,
        ACT_EXIT    = 3'd3,
        ACT_HOLD    = 3'd4
    } t_action;

    // headings
    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [1:0] CFG_ENTRY_ROW = 2'd1;
    localparam logic [1:0] CFG_ENTRY_COL = 2'd2;

    // configuration reset values
    localparam logic [4:0] GRID_SIZE_RST = 5'd16;
    localparam logic [3:0] ENTRY_ROW_RST = 4'd2;
    localparam logic [3:0] ENTRY_COL_RST = 4'd0;

    // input word
    typedef struct packed {
        t_kind      kind;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic       cell_is_wall;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [3:0] pos_row;
        logic [3:0] pos_col;
        logic [1:0] heading;
        t_action    action;
        logic       exit_reached;
    } t_out_word;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EVAL = 1'b1
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic rd;
        logic eval;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_valid;
    } t_dp_sts;

endpackage

[rtl/core/rhmw_ctrl.sv]
// controller: accepts input words and sequences the lookup and decision phases of a step
module rhmw_ctrl
    import rhmw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_kind   i_kind,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   out_free;
    logic   accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        out_free   = !i_sts.out_valid || !i_out_stall;
        o_in_stall = !((r_state == ST_IDLE) && out_free);
        accept     = i_in_valid && !o_in_stall;
        o_cmd      = '0;
        n_state    = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load  = accept && (i_kind == KIND_LOAD);
                o_cmd.start = accept && (i_kind == KIND_START);
                o_cmd.rd    = accept && (i_kind == KIND_STEP);
                if (o_cmd.rd) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/rhmw_datapath.sv]
// datapath: wall store, walker state, configuration and result register
module rhmw_datapath
    import rhmw_pkg::*;
#(
    parameter int MAX_GRID = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  t_in_word   i_in_word,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic [4:0] i_cfg_data,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_out_word  o_out_word
);

    localparam int CW    = $clog2(MAX_GRID);
    localparam int GW    = (CW + 1 > 5) ? CW + 1 : 5;
    localparam int EW    = (CW > 4) ? CW : 4;
    localparam int DEPTH = MAX_GRID * MAX_GRID;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [4:0] r_grid_size;
    logic [3:0] r_entry_row;
    logic [3:0] r_entry_col;

    // walker state
    logic [CW-1:0] r_walker_row, n_walker_row;
    logic [CW-1:0] r_walker_col, n_walker_col;
    logic [1:0]    r_facing, n_facing;
    logic [CW-1:0] r_hand_row, n_hand_row;
    logic [CW-1:0] r_hand_col, n_hand_col;
    logic          r_finished, n_finished;
    t_action       n_action;

    // step lookup stage
    logic          r_mem [DEPTH];
    logic          r_front_wall;
    logic          r_right_wall;
    logic [CW-1:0] r_front_row, r_front_col;
    logic [CW-1:0] r_right_row, r_right_col;

    logic          r_out_valid;
    t_out_word     r_out_word;

    logic [GW-1:0]   size_ext;
    logic [GW-1:0]   size_eff;
    logic [CW-1:0]   s_m1;
    logic [2*CW-1:0] front_rc;
    logic [2*CW-1:0] right_rc;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   front_addr;
    logic [AW-1:0]   right_addr;
    logic            load_in_range;
    logic [EW-1:0]   s_m1_ext;
    logic [EW-1:0]   entry_row_ext;
    logic [EW-1:0]   entry_col_ext;
    logic            front_same;
    logic            on_border;
    logic            hand_hit;

    // clamped cell one step ahead in a direction
    function automatic logic [2*CW-1:0] ahead(
        input logic [CW-1:0] sm1,
        input logic [1:0]    dir,
        input logic [CW-1:0] r,
        input logic [CW-1:0] c
    );
        logic [CW-1:0] nr;
        logic [CW-1:0] nc;
        nr = r;
        nc = c;
        unique case (dir)
            DIR_EAST:  nc = (c < sm1) ? c + 1'b1 : sm1;
            DIR_SOUTH: nr = (r < sm1) ? r + 1'b1 : sm1;
            DIR_WEST:  nc = (c != '0) ? c - 1'b1 : '0;
            DIR_NORTH: nr = (r != '0) ? r - 1'b1 : '0;
            default:   nr = r;
        endcase
        return {nr, nc};
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
            r_entry_row <= ENTRY_ROW_RST;
            r_entry_col <= ENTRY_COL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_SIZE: r_grid_size <= i_cfg_data;
                CFG_ENTRY_ROW: r_entry_row <= i_cfg_data[3:0];
                CFG_ENTRY_COL: r_entry_col <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective side length, kept as side minus one
    always_comb begin
        size_ext = GW'(r_grid_size);
        if (size_ext < GW'(2)) begin
            size_eff = GW'(2);
        end else if (size_ext > GW'(MAX_GRID)) begin
            size_eff = GW'(MAX_GRID);
        end else begin
            size_eff = size_ext;
        end
        s_m1 = CW'(size_eff - GW'(1));
    end

    // front and right neighbors and store addresses
    always_comb begin
        front_rc      = ahead(s_m1, r_facing, r_walker_row, r_walker_col);
        right_rc      = ahead(s_m1, r_facing + 2'd1, r_walker_row, r_walker_col);
        front_addr    = AW'(32'(front_rc[2*CW-1:CW]) * MAX_GRID + 32'(front_rc[CW-1:0]));
        right_addr    = AW'(32'(right_rc[2*CW-1:CW]) * MAX_GRID + 32'(right_rc[CW-1:0]));
        load_in_range = (32'(i_in_word.cell_row) < MAX_GRID)
                     && (32'(i_in_word.cell_col) < MAX_GRID);
        wr_addr       = AW'(32'(i_in_word.cell_row) * MAX_GRID + 32'(i_in_word.cell_col));
    end

    // wall store: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_in_range) begin
            r_mem[wr_addr] <= i_in_word.cell_is_wall;
        end
        if (i_cmd.rd) begin
            r_front_wall <= r_mem[front_addr];
            r_right_wall <= r_mem[right_addr];
        end
    end

    // neighbor coordinates held for the decision cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_front_row <= front_rc[2*CW-1:CW];
            r_front_col <= front_rc[CW-1:0];
            r_right_row <= right_rc[2*CW-1:CW];
            r_right_col <= right_rc[CW-1:0];
        end
    end

    // start placement and right-hand rule decision
    always_comb begin
        s_m1_ext      = EW'(s_m1);
        entry_row_ext = EW'(r_entry_row);
        entry_col_ext = EW'(r_entry_col);
        front_same    = (r_front_row == r_walker_row) && (r_front_col == r_walker_col);
        on_border     = (((r_walker_row == s_m1) || (r_walker_row == '0))
                          && (r_walker_col <= s_m1))
                     || (((r_walker_col == s_m1) || (r_walker_col == '0))
                          && (r_walker_row <= s_m1));
        hand_hit      = r_right_wall
                     || ((r_right_row == r_hand_row) && (r_right_col == r_hand_col));

        n_walker_row = r_walker_row;
        n_walker_col = r_walker_col;
        n_facing     = r_facing;
        n_hand_row   = r_hand_row;
        n_hand_col   = r_hand_col;
        n_finished   = r_finished;
        n_action     = ACT_HOLD;

        if (i_cmd.start) begin
            n_walker_row = CW'((entry_row_ext < s_m1_ext) ? entry_row_ext : s_m1_ext);
            n_walker_col = CW'((entry_col_ext < s_m1_ext) ? entry_col_ext : s_m1_ext);
            n_facing     = DIR_EAST;
            n_hand_row   = '0;
            n_hand_col   = '0;
            n_finished   = 1'b0;
        end else begin
            // hand follows a wall on the right
            if (r_right_wall) begin
                n_hand_row = r_right_row;
                n_hand_col = r_right_col;
            end
            priority if (front_same && on_border) begin
                n_finished = 1'b1;
                n_action   = ACT_EXIT;
            end else if (r_front_wall && r_right_wall) begin
                n_facing = r_facing + 2'd3;
                n_action = ACT_LEFT;
            end else if (!r_front_wall && hand_hit) begin
                n_walker_row = r_front_row;
                n_walker_col = r_front_col;
                n_action     = ACT_FORWARD;
            end else if (!r_right_wall) begin
                n_facing     = r_facing + 2'd1;
                n_walker_row = r_right_row;
                n_walker_col = r_right_col;
                n_action     = ACT_RIGHT;
            end else begin
                n_action = ACT_HOLD;
            end
        end
    end

    // walker state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walker_row <= '0;
            r_walker_col <= '0;
            r_facing     <= DIR_EAST;
            r_hand_row   <= '0;
            r_hand_col   <= '0;
            r_finished   <= 1'b0;
        end else if (i_cmd.start || i_cmd.eval) begin
            r_walker_row <= n_walker_row;
            r_walker_col <= n_walker_col;
            r_facing     <= n_facing;
            r_hand_row   <= n_hand_row;
            r_hand_col   <= n_hand_col;
            r_finished   <= n_finished;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.start || i_cmd.eval) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start || i_cmd.eval) begin
            r_out_word.pos_row      <= 4'(n_walker_row);
            r_out_word.pos_col      <= 4'(n_walker_col);
            r_out_word.heading      <= n_facing;
            r_out_word.action       <= n_action;
            r_out_word.exit_reached <= n_finished;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_word    = r_out_word;
    assign o_sts.out_valid = r_out_valid;

endmodule

[rtl/core/right_hand_maze_walker_core.sv]
// Right-hand wall follower over a square wall grid of MAX_GRID x MAX_GRID cells.
// Load words write one wall bit into the store and give no result; start words place
// the walker at the clamped entrance facing east and return one result in the cycle
// after acceptance; step words return one result each. For a step the store is read
// at both the front and right cells when the step is accepted, and the registered
// wall bits drive the decision in the following cycle, so no new input word is taken
// until that decision is made. The wall store has no reset; every cell the walker may
// look at must be loaded before a walk. The configuration port is always ready; the
// user must write it only while the block is idle, which the block does not enforce.
module right_hand_maze_walker_core
    import rhmw_pkg::*;
#(
    parameter int MAX_GRID = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencing
    rhmw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in_word.kind),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    // store, walker and result
    rhmw_datapath #(
        .MAX_GRID (MAX_GRID)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

[rtl/core/rhmw_checker.sv]
// port-level checks for the maze walker and their binding
module rhmw_port_checks
    import rhmw_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    logic in_take;
    assign in_take = i_in_valid && !o_in_stall;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // a step keeps the input side busy for its decision cycle
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && (i_in_word.kind == KIND_STEP) |=> o_in_stall)
        else $error("input taken during step decision");

    // a start shows a held walker with no exit right away
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && (i_in_word.kind == KIND_START) |=>
            o_out_valid && (o_out_word.action == ACT_HOLD) && !o_out_word.exit_reached)
        else $error("start result missing or wrong");

    // an exit report always carries the exit flag
    a_exit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.action == ACT_EXIT) |-> o_out_word.exit_reached)
        else $error("exit action without exit flag");

endmodule

bind right_hand_maze_walker_core rhmw_port_checks u_rhmw_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
